// ===== design/quadrature_sine_generator_macros.svh =====
// Assertion helpers for the top-level module.
`ifndef QUADRATURE_SINE_GENERATOR_MACROS_SVH
`define QUADRATURE_SINE_GENERATOR_MACROS_SVH

// Same-cycle implication, idle during reset.
`define QSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define QSG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/qsg_pkg.sv =====
`default_nettype none
package qsg_pkg;
    localparam int CORDIC_STAGES_DEF   = 18;
    localparam int ANGLE_FRAC_BITS_DEF = 24;
    localparam int PW     = 18;   // phase, rate and tone width
    localparam int XW     = 34;   // CORDIC x/y width
    localparam int ZW     = 33;   // CORDIC angle width
    localparam int CNT_W  = 6;    // divider iteration count
    localparam int TAB_LEN = 24;
    localparam logic signed [XW-1:0] START_X = 34'sd1304025951;

    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_TONE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODP,
        ST_FRAC,
        ST_STEP,
        ST_CORD
    } state_t;

    typedef struct packed {
        logic            start;
        logic [PW-1:0]   rem_init;
        logic [PW-1:0]   value;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic               vld;
        logic [1:0]         quad;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 33'sd536870912;
            1:  r = 33'sd316933406;
            2:  r = 33'sd167458907;
            3:  r = 33'sd85004756;
            4:  r = 33'sd42667331;
            5:  r = 33'sd21354465;
            6:  r = 33'sd10679838;
            7:  r = 33'sd5340245;
            8:  r = 33'sd2670163;
            9:  r = 33'sd1335087;
            10: r = 33'sd667544;
            11: r = 33'sd333772;
            12: r = 33'sd166886;
            13: r = 33'sd83443;
            14: r = 33'sd41722;
            15: r = 33'sd20861;
            16: r = 33'sd10430;
            17: r = 33'sd5215;
            18: r = 33'sd2608;
            19: r = 33'sd1304;
            20: r = 33'sd652;
            21: r = 33'sd326;
            22: r = 33'sd163;
            23: r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round Q16 half up and clamp to the symmetric 16-bit range
    function automatic logic signed [15:0] to_sample(input logic signed [XW-1:0] v);
        logic signed [XW:0] s;
        logic signed [XW:0] r;
        s = (XW+1)'(v) + (XW+1)'(32768);
        r = s >>> 16;
        if (r > (XW+1)'(32767)) begin
            return 16'sd32767;
        end else if (r < -(XW+1)'(32767)) begin
            return -16'sd32767;
        end
        return 16'(r);
    endfunction
endpackage
`default_nettype wire

// ===== design/qsg_div.sv =====
`default_nettype none
module qsg_div
    import qsg_pkg::*;
#(
    parameter int QW = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire div_req_t      req,
    input  wire logic [PW-1:0] divisor,
    output logic [PW-1:0]      rem,
    output logic [QW-1:0]      quot,
    output logic               done
);
    logic [PW-1:0]    rem_reg, val_reg;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [PW:0]      rem_sh;
    logic             ge;
    logic [PW-1:0]    rem_next;

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {rem_reg, val_reg[PW-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_next = ge ? PW'(rem_sh - {1'b0, divisor}) : rem_sh[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem_init;
            val_reg <= req.value;
            q_reg   <= '0;
            cnt_reg <= req.iters;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            val_reg <= val_reg << 1;
            q_reg   <= {q_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rem  = rem_reg;
    assign quot = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== design/qsg_cell.sv =====
`default_nettype none
module qsg_cell
    import qsg_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cordic_t din,
    output cordic_t      dout
);
    cordic_t nxt;
    cordic_t q_reg;

    // Rotate one micro-step toward zero residual angle
    always_comb begin
        nxt = din;
        if (!din.z[ZW-1]) begin
            nxt.x = din.x - (din.y >>> IDX);
            nxt.y = din.y + (din.x >>> IDX);
            nxt.z = din.z - atan_turn(IDX);
        end else begin
            nxt.x = din.x + (din.y >>> IDX);
            nxt.y = din.y - (din.x >>> IDX);
            nxt.z = din.z + atan_turn(IDX);
        end
    end

    // Advance the vector to the neighbor; only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else begin
            q_reg.vld <= nxt.vld;
        end
        q_reg.quad <= nxt.quad;
        q_reg.x    <= nxt.x;
        q_reg.y    <= nxt.y;
        q_reg.z    <= nxt.z;
    end

    assign dout = q_reg;
endmodule
`default_nettype wire

// ===== design/qsg_chain.sv =====
`default_nettype none
module qsg_chain
    import qsg_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cordic_t din,
    output cordic_t      dout
);
    cordic_t link [STAGES+1];

    assign link[0] = din;

    // One cell per CORDIC iteration, passing to its neighbor each cycle
    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        qsg_cell #(.IDX(i)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .din    (link[i]),
            .dout   (link[i+1])
        );
    end

    assign dout = link[STAGES];
endmodule
`default_nettype wire

// ===== design/quadrature_sine_generator.sv =====
// Quadrature tone generator.
// A request on the s_ channel (s_valid/s_ready, field s_restart) asks for
// the next sine/cosine pair; s_restart zeroes the sample index and phase
// first. Each request yields one result on the m_ channel (m_left_sine,
// m_right_cosine, m_last_sample) until sample_count pairs have gone out;
// after that a request yields nothing until a restart.
// Registers sit on an APB port: sample_rate at 0x0, tone_freq at 0x4,
// sample_count at 0x8; write them only while the block is idle.
// One request is worked at a time; the next is accepted only once the
// block is back in idle. A shared bit-serial divider runs the phase
// reduction, the angle fraction and the tone reduction in turn, and then
// the output register is loaded. The tone reduction hides the
// CORDIC_STAGES-cell rotation chain as long as the chain takes no longer
// than it; a longer chain delays the load. A request that yields no
// result ends after the phase reduction.
// The result sits in an output register; the next request is taken while
// it waits. If the receiver stalls, the next result is held inside and
// the input stalls until the register frees up.
// Reset restores the register defaults and zeroes index and phase.
`default_nettype none
`include "quadrature_sine_generator_macros.svh"
module quadrature_sine_generator
    import qsg_pkg::*;
#(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_left_sine,
    output logic signed [15:0] m_right_cosine,
    output logic             m_last_sample
);
    logic [PW-1:0] rate_reg, tone_reg;
    logic [31:0]   count_reg;
    logic [PW-1:0] fs;
    logic          wr;

    state_t state_reg, state_next;
    logic [31:0]   idx_reg, idx_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [PW-1:0] step_reg, step_next;
    logic [PW:0]   phase_sum;

    div_req_t      dreq;
    logic [PW-1:0] div_rem;
    logic [ANGLE_FRAC_BITS-1:0] div_q;
    logic          div_done;
    logic [31:0]   angle;
    cordic_t       c_in, c_out;

    logic          pend_vld_reg;
    logic signed [15:0] pend_sin_reg, pend_cos_reg;
    logic          out_load;
    logic signed [15:0] c_sin, c_cos;

    // Configuration registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= PW'(16000);
            tone_reg  <= PW'(1000);
            count_reg <= 32'd16000;
        end else if (wr) begin
            case (paddr[3:2])
                REG_RATE:  rate_reg  <= pwdata[PW-1:0];
                REG_TONE:  tone_reg  <= pwdata[PW-1:0];
                REG_COUNT: count_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RATE:  prdata = 32'(rate_reg);
            REG_TONE:  prdata = 32'(tone_reg);
            REG_COUNT: prdata = count_reg;
            default:   prdata = '0;
        endcase
    end

    assign fs = (rate_reg == '0) ? PW'(1) : rate_reg;

    qsg_div #(.QW(ANGLE_FRAC_BITS)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dreq),
        .divisor(fs),
        .rem    (div_rem),
        .quot   (div_q),
        .done   (div_done)
    );

    assign angle = 32'(64'(div_q) << (32 - ANGLE_FRAC_BITS));

    qsg_chain #(.STAGES(CORDIC_STAGES)) u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .din    (c_in),
        .dout   (c_out)
    );

    // Fold the rotated vector back into its quadrant and round
    always_comb begin
        case (c_out.quad)
            2'd0: begin
                c_sin = to_sample(c_out.y);
                c_cos = to_sample(c_out.x);
            end
            2'd1: begin
                c_sin = to_sample(c_out.x);
                c_cos = to_sample(-c_out.y);
            end
            2'd2: begin
                c_sin = to_sample(-c_out.y);
                c_cos = to_sample(-c_out.x);
            end
            default: begin
                c_sin = to_sample(-c_out.x);
                c_cos = to_sample(c_out.y);
            end
        endcase
    end

    // Sequencer: next state, divider requests, chain launch, output load
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        dreq       = '0;
        c_in       = '0;
        out_load   = 1'b0;
        s_ready    = (state_reg == ST_IDLE);
        phase_sum  = {1'b0, phase_reg} + {1'b0, step_reg};
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart) begin
                        idx_next   = '0;
                        phase_next = '0;
                    end
                    dreq.start    = 1'b1;
                    dreq.rem_init = '0;
                    dreq.value    = s_restart ? '0 : phase_reg;
                    dreq.iters    = CNT_W'(PW);
                    state_next    = ST_MODP;
                end
            end
            ST_MODP: begin
                if (div_done) begin
                    phase_next = div_rem;
                    if (idx_reg >= count_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        dreq.start    = 1'b1;
                        dreq.rem_init = div_rem;
                        dreq.value    = '0;
                        dreq.iters    = CNT_W'(ANGLE_FRAC_BITS);
                        state_next    = ST_FRAC;
                    end
                end
            end
            ST_FRAC: begin
                if (div_done) begin
                    c_in.vld      = 1'b1;
                    c_in.quad     = angle[31:30];
                    c_in.x        = START_X;
                    c_in.y        = '0;
                    c_in.z        = ZW'({2'b00, angle[29:0]});
                    dreq.start    = 1'b1;
                    dreq.rem_init = '0;
                    dreq.value    = tone_reg;
                    dreq.iters    = CNT_W'(PW);
                    state_next    = ST_STEP;
                end
            end
            ST_STEP: begin
                if (div_done) begin
                    step_next  = div_rem;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                if (pend_vld_reg && (!m_valid || m_ready)) begin
                    out_load   = 1'b1;
                    idx_next   = idx_reg + 32'd1;
                    phase_next = (phase_sum >= {1'b0, fs}) ?
                                 PW'(phase_sum - {1'b0, fs}) : phase_sum[PW-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
    end

    // Hold the chain result until the output register frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
        end else if (c_out.vld) begin
            pend_vld_reg <= 1'b1;
        end else if (out_load) begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_out.vld) begin
            pend_sin_reg <= c_sin;
            pend_cos_reg <= c_cos;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_left_sine    <= pend_sin_reg;
            m_right_cosine <= pend_cos_reg;
            m_last_sample  <= (idx_reg == count_reg - 32'd1);
        end
    end

    `QSG_ASSERT_IMP(a_phase_reduced, aclk, aresetn, state_reg == ST_CORD, phase_reg < fs)
    `QSG_ASSERT_NXT(a_load_idle, aclk, aresetn, out_load, state_reg == ST_IDLE && m_valid)
    `QSG_ASSERT_IMP(a_one_item, aclk, aresetn, c_out.vld, state_reg == ST_STEP || state_reg == ST_CORD)
endmodule
`default_nettype wire

// ===== test/qsg_checker.sv =====
`default_nettype none
module qsg_checker
    import qsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_restart,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic signed [15:0] m_left_sine,
    input  wire logic signed [15:0] m_right_cosine,
    input  wire logic        m_last_sample,
    output int               error_count,
    output int               pending_count,
    output int               pair_count,
    output int               last_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] sine;
        logic signed [15:0] cosine;
        logic               last;
    } tone_pair_t;

    // arctangent of 2^-i in units of 2^32 per turn
    localparam longint ROT_ANGLE [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic [PW-1:0] rate_reg;
    logic [PW-1:0] tone_reg;
    logic [31:0]   count_reg;
    logic [31:0]   index_q;
    logic [PW-1:0] phase_q;
    tone_pair_t    pair_queue[$];

    assign pending_count = pair_queue.size();

    // round Q16 half up, clamp to the symmetric range
    function automatic logic signed [15:0] round_amp(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        return 16'(r);
    endfunction

    // rotate within the quadrant, then fold the quadrant back in
    function automatic void rotate_angle(input logic [31:0] angle,
                                         output logic signed [15:0] sn,
                                         output logic signed [15:0] cs);
        longint x, y, z, dx, dy;
        x = 1304025951;
        y = 0;
        z = longint'(angle[29:0]);
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ROT_ANGLE[i];
            end else begin
                x += dx; y -= dy; z += ROT_ANGLE[i];
            end
        end
        case (angle[31:30])
            2'd0: begin sn = round_amp(y);  cs = round_amp(x);  end
            2'd1: begin sn = round_amp(x);  cs = round_amp(-y); end
            2'd2: begin sn = round_amp(-y); cs = round_amp(-x); end
            default: begin sn = round_amp(-x); cs = round_amp(y); end
        endcase
    endfunction

    // advance the tone state by one request; push the pair it yields
    function automatic void predict_pair(input logic restart);
        logic [PW-1:0] fs, p, step;
        logic [63:0]   frac;
        logic [31:0]   angle;
        tone_pair_t    t;
        fs = (rate_reg == 0) ? PW'(1) : rate_reg;
        if (restart) begin
            index_q = 0;
            phase_q = 0;
        end
        p = phase_q % fs;
        phase_q = p;
        if (index_q >= count_reg) return;
        frac = (64'(p) << ANGLE_FRAC_BITS_DEF) / fs;
        angle = 32'(frac << (32 - ANGLE_FRAC_BITS_DEF));
        rotate_angle(angle, t.sine, t.cosine);
        t.last = (index_q == count_reg - 32'd1);
        pair_queue.push_back(t);
        index_q++;
        step = tone_reg % fs;
        p = PW'((19'(p) + 19'(step)) >= 19'(fs) ? p + step - fs : p + step);
        phase_q = p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= 18'd16000;
            tone_reg  <= 18'd1000;
            count_reg <= 32'd16000;
            index_q   = 0;
            phase_q   = 0;
            pair_queue.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_RATE:  rate_reg  <= pwdata[PW-1:0];
                    REG_TONE:  tone_reg  <= pwdata[PW-1:0];
                    REG_COUNT: count_reg <= pwdata;
                    default: ;
                endcase
            end
            // compare the delivered pair with the oldest prediction
            if (m_valid && m_ready) begin
                if (pair_queue.size() == 0) begin
                    $error("unexpected result: sine %0d cosine %0d",
                           m_left_sine, m_right_cosine);
                    error_count++;
                end else begin
                    tone_pair_t t;
                    t = pair_queue.pop_front();
                    pair_count++;
                    if (m_last_sample) last_count++;
                    if (m_left_sine !== t.sine) begin
                        $error("left_sine: expected %0d, got %0d", t.sine, m_left_sine);
                        error_count++;
                    end
                    if (m_right_cosine !== t.cosine) begin
                        $error("right_cosine: expected %0d, got %0d",
                               t.cosine, m_right_cosine);
                        error_count++;
                    end
                    if (m_last_sample !== t.last) begin
                        $error("last_sample: expected %0d, got %0d",
                               t.last, m_last_sample);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_pair(s_restart);
        end
    end

    initial begin
        error_count = 0;
        pair_count = 0;
        last_count = 0;
    end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
    import qsg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready, s_restart = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic signed [15:0] m_left_sine, m_right_cosine;
    logic m_last_sample;

    int error_count, pending_count, pair_count, last_count;
    int request_total = 0;
    bit quiet = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    quadrature_sine_generator u_top (.*);

    qsg_checker u_checker (.*);

    // drop ready in random bursts; honor one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // drop the request, hold until every predicted pair has gone out,
    // then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_tone(input logic [31:0] rate, input logic [31:0] tone,
                            input logic [31:0] cnt);
        drain();
        reg_write(REG_RATE, rate);
        reg_write(REG_TONE, tone);
        reg_write(REG_COUNT, cnt);
    endtask

    // offer one request and hold it until accepted; valid stays up for
    // the next request unless an idle burst or a drain drops it
    task automatic send_request(input logic restart);
        bit fire;
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do begin
            @(negedge aclk);
            fire = s_ready;
            @(posedge aclk);
        end while (!fire);
        request_total++;
    endtask

    task automatic run_requests(input int n, input int restart_pct);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(0, 99) < restart_pct);
    endtask

    initial begin
        int cnt;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, fresh stream
        run_requests(4, 0);
        // short count: last flag, then requests past the end, then restart
        set_tone(48000, 1000, 3);
        run_requests(5, 0);
        send_request(1'b1);
        run_requests(3, 0);
        // zero count never yields a pair
        set_tone(48000, 1000, 0);
        run_requests(2, 0);
        send_request(1'b1);
        // zero rate acts as one
        set_tone(0, 5, 32'hFFFF_FFFF);
        send_request(1'b1);
        run_requests(2, 0);
        // extremes of rate and tone
        set_tone(1, 0, 32'hFFFF_FFFF);
        run_requests(2, 0);
        set_tone(262143, 262143, 100);
        send_request(1'b1);
        run_requests(2, 0);
        // quarter-turn steps hit every quadrant boundary
        set_tone(4, 1, 100);
        send_request(1'b1);
        run_requests(4, 0);
        // grow the rate mid stream without a restart
        set_tone(7, 3, 100);
        run_requests(2, 0);

        // random settings, mostly long streams with the odd restart
        for (int ph = 0; ph < 12; ph++) begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                              : $urandom_range(200, 100000);
            if (ph == 11) cnt = 32'hFFFF_FFFF;
            set_tone(($urandom_range(0, 2) == 0) ? $urandom_range(0, 64)
                                                 : $urandom_range(0, 262143),
                     $urandom_range(0, 262143), cnt);
            if (ph == 4) hold_off = 1'b1;
            if (ph == 10) quiet = 1'b1;
            send_request(1'b1);
            run_requests(120, 3);
        end

        drain();
        $display("Ran %0d requests across directed and random tone settings.",
                 request_total);
        $display("Checked %0d sine/cosine pairs, %0d flagged last.",
                 pair_count, last_count);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
